// File: hdl/kpq_pkg.sv
// Shared types and constants for the keypad press qualifier.
package kpq_pkg;

    localparam int KeyW       = 8;
    localparam int PressW     = 4;
    localparam int ReleaseW   = 8;
    localparam int CfgIndexW  = 2;
    localparam int CfgDataW   = 8;
    localparam int InDataW    = 16;
    localparam int OutDataW   = 16;

    localparam logic [PressW-1:0]    PressScansReset   = 4'd2;
    localparam logic [ReleaseW-1:0]  ReleaseScansReset = 8'd8;

    localparam logic [CfgIndexW-1:0] CfgPressScans   = 2'd0;
    localparam logic [CfgIndexW-1:0] CfgReleaseScans = 2'd1;

    localparam logic KindScan    = 1'b0;
    localparam logic KindConsume = 1'b1;

    typedef struct packed {
        logic            kind;
        logic            scan_ok;
        logic            key_down;
        logic [KeyW-1:0] key_code;
    } t_item;

    typedef struct packed {
        logic [KeyW-1:0] consumed_key;
        logic            event_pending;
        logic            latched;
    } t_result;

endpackage

// File: hdl/kpq_core.sv
// Qualifier state (event slot, latch, candidate, counters) and its per-request update.
module kpq_core
    import kpq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  t_item               i_item,
    input  logic [PressW-1:0]   i_press_scans,
    input  logic [ReleaseW-1:0] i_release_scans,
    output t_result             o_result
);

    logic [KeyW-1:0]     r_slot,  n_slot;
    logic                r_latch, n_latch;
    logic [KeyW-1:0]     r_cand,  n_cand;
    logic [PressW-1:0]   r_pcnt,  n_pcnt;
    logic [ReleaseW-1:0] r_rcnt,  n_rcnt;
    logic [KeyW-1:0]     consumed;

    always_comb begin
        n_slot   = r_slot;
        n_latch  = r_latch;
        n_cand   = r_cand;
        n_pcnt   = r_pcnt;
        n_rcnt   = r_rcnt;
        consumed = '0;
        if (i_item.kind == KindConsume) begin
            consumed = r_slot;
            n_slot   = '0;
        end else if (i_item.scan_ok) begin
            if (!i_item.key_down) begin
                // count idle scans, then drop the latch and clear candidate and press count once the count is full
                if (r_rcnt < i_release_scans) begin
                    n_rcnt = r_rcnt + 8'd1;
                end else begin
                    n_latch = 1'b0;
                    n_cand  = '0;
                    n_pcnt  = '0;
                end
            end else if (r_slot == '0) begin
                n_rcnt = '0;
                if (!r_latch && (i_item.key_code != '0)) begin
                    if (i_item.key_code == r_cand) begin
                        if (r_pcnt < i_press_scans) begin
                            n_pcnt = r_pcnt + 4'd1;
                        end
                    end else begin
                        n_cand = i_item.key_code;
                        n_pcnt = 4'd1;
                    end
                    if (n_pcnt >= i_press_scans) begin
                        n_slot  = i_item.key_code;
                        n_latch = 1'b1;
                    end
                end
            end
        end
    end

    assign o_result.consumed_key  = consumed;
    assign o_result.event_pending = (n_slot != '0);
    assign o_result.latched       = n_latch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_latch <= 1'b0;
            r_cand  <= '0;
            r_pcnt  <= '0;
            r_rcnt  <= '0;
        end else if (i_step) begin
            r_slot  <= n_slot;
            r_latch <= n_latch;
            r_cand  <= n_cand;
            r_pcnt  <= n_pcnt;
            r_rcnt  <= n_rcnt;
        end
    end

endmodule

// File: hdl/keypad_press_qualifier_unit.sv
// Top level of the keypad press qualifier: stream ports, config registers, pipeline registers.
//
// Usage: each request on the slave stream is either a scan tick (tuser = 0) carrying the
// scan-ok flag, the key-down flag and the decoded key code, or a consume request
// (tuser = 1) that takes the pending key event out of the one-entry slot. Every request
// yields exactly one result on the master stream: the consumed key (0 on scans or on an
// empty slot), whether an event is still pending, and the press latch.
// The config channel writes press_scans (index 0) and release_scans (index 1); other
// indexes are dropped. Write it only while no request is in flight.
// A request passes the input register, then the state update into the result register.
// Throughput: one request per cycle while the receiver does not stall, set by the
// combinational compare-and-count update of the qualifier state.
// Reset (synchronous, active low) empties the slot, clears latch, candidate and both
// counters, loads the default thresholds and empties both pipeline registers.
// When the receiver stalls, the result register holds its value; the input register still
// takes one more request, after which tready drops until the result drains.
module keypad_press_qualifier_unit
    import kpq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [InDataW-1:0]   i_s_axis_tdata,  // [0] scan_ok, [1] key_down, [9:2] key_code
    input  logic                 i_s_axis_tuser,  // [0] kind
    // result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [OutDataW-1:0]  o_m_axis_tdata,  // [7:0] consumed_key, [8] event_pending,
                                                  // [9] latched
    // config write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CfgIndexW-1:0] i_cfg_index,
    input  logic [CfgDataW-1:0]  i_cfg_data
);

    logic [PressW-1:0]   r_press_scans;
    logic [ReleaseW-1:0] r_release_scans;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;
    t_result step_result;
    logic    advance;

    // the config channel never stalls
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_scans   <= PressScansReset;
            r_release_scans <= ReleaseScansReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CfgPressScans:   r_press_scans   <= i_cfg_data[PressW-1:0];
                CfgReleaseScans: r_release_scans <= i_cfg_data[ReleaseW-1:0];
                default:         ;
            endcase
        end
    end

    // advance the held request into the result register when that slot frees up
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_item.kind     <= i_s_axis_tuser;
            r_in_item.scan_ok  <= i_s_axis_tdata[0];
            r_in_item.key_down <= i_s_axis_tdata[1];
            r_in_item.key_code <= i_s_axis_tdata[KeyW+1:2];
        end
    end

    kpq_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (advance),
        .i_item          (r_in_item),
        .i_press_scans   (r_press_scans),
        .i_release_scans (r_release_scans),
        .o_result        (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OutDataW-KeyW-2){1'b0}},
                              r_out.latched, r_out.event_pending, r_out.consumed_key};

    // a consume that returned a key always leaves the slot empty
    a_consume_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[KeyW-1:0] != '0)) |-> !o_m_axis_tdata[KeyW])
        else $error("result returned a key but still reports a pending event");

    // a request that advances always shows up as a result next cycle
    a_advance_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_m_axis_tvalid)
        else $error("advanced request produced no result");

    // backpressure only when both registers are full
    a_ready_low_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_in_valid && r_out_valid && !i_m_axis_tready))
        else $error("input stalled while a register was free");

endmodule

// File: dv/kpq_press_checker.sv
// Checker for the keypad press qualifier: watches all channels, predicts and compares results.
module kpq_press_checker
    import kpq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    input  logic [InDataW-1:0]   i_req_data,
    input  logic                 i_req_user,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  logic [OutDataW-1:0]  i_res_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CfgIndexW-1:0] i_cfg_index,
    input  logic [CfgDataW-1:0]  i_cfg_data,
    output int                   o_outstanding,
    output int                   o_errors
);

    logic [PressW-1:0]   press_need;
    logic [ReleaseW-1:0] release_need;
    logic [KeyW-1:0]     slot_key;
    logic                latch_on;
    logic [KeyW-1:0]     cand_key;
    logic [PressW-1:0]   press_run;
    logic [ReleaseW-1:0] idle_run;

    t_result expected_q[$];
    int      mismatch_count = 0;
    int      result_index = 0;

    assign o_errors = mismatch_count;

    task automatic report_mismatch(input string what);
        $display("kpq check: result %0d %s", result_index, what);
        mismatch_count++;
    endtask

    // Advance the qualifier state by one request and return the result it yields.
    function automatic t_result qualify_request(input t_item req);
        t_result res;
        res = '0;
        if (req.kind == KindConsume) begin
            res.consumed_key = slot_key;
            slot_key = '0;
        end else if (req.scan_ok) begin
            if (!req.key_down) begin
                if (idle_run < release_need) begin
                    idle_run = idle_run + 8'd1;
                end else begin
                    latch_on  = 1'b0;
                    cand_key  = '0;
                    press_run = '0;
                end
            end
            // a pending event freezes press handling, release counting goes on
            if (slot_key == '0 && req.key_down) begin
                idle_run = '0;
                if (!latch_on && req.key_code != '0) begin
                    if (req.key_code == cand_key) begin
                        if (press_run < press_need)
                            press_run = press_run + 4'd1;
                    end else begin
                        cand_key  = req.key_code;
                        press_run = 4'd1;
                    end
                    if (press_run >= press_need) begin
                        slot_key = cand_key;
                        latch_on = 1'b1;
                    end
                end
            end
        end
        res.event_pending = (slot_key != '0);
        res.latched       = latch_on;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_item   req;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            press_need   = PressScansReset;
            release_need = ReleaseScansReset;
            slot_key     = '0;
            latch_on     = 1'b0;
            cand_key     = '0;
            press_run    = '0;
            idle_run     = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CfgPressScans)
                    press_need = i_cfg_data[PressW-1:0];
                else if (i_cfg_index == CfgReleaseScans)
                    release_need = i_cfg_data[ReleaseW-1:0];
            end
            if (i_req_valid && i_req_ready) begin
                req.kind     = i_req_user;
                req.scan_ok  = i_req_data[0];
                req.key_down = i_req_data[1];
                req.key_code = i_req_data[KeyW+1:2];
                expected_q.push_back(qualify_request(req));
            end
            if (i_res_valid && i_res_ready) begin
                got.consumed_key  = i_res_data[KeyW-1:0];
                got.event_pending = i_res_data[KeyW];
                got.latched       = i_res_data[KeyW+1];
                if (expected_q.size() == 0) begin
                    report_mismatch("arrived with nothing expected");
                end else begin
                    want = expected_q.pop_front();
                    if (got.consumed_key != want.consumed_key)
                        report_mismatch($sformatf("consumed_key got %0d want %0d",
                                                  got.consumed_key, want.consumed_key));
                    if (got.event_pending != want.event_pending)
                        report_mismatch($sformatf("event_pending got %0d want %0d",
                                                  got.event_pending, want.event_pending));
                    if (got.latched != want.latched)
                        report_mismatch($sformatf("latched got %0d want %0d",
                                                  got.latched, want.latched));
                end
                result_index++;
            end
        end
        o_outstanding <= expected_q.size();
    end

endmodule

// File: dv/tb_keypad_press_qualifier_unit.sv
// Testbench top for the keypad press qualifier: clock, reset, stimulus and final verdict.
module tb_keypad_press_qualifier_unit;
    import kpq_pkg::*;

    // index values the block has no register for; writes to them must be dropped
    localparam logic [CfgIndexW-1:0] CfgSpareLow  = 2'd2;
    localparam logic [CfgIndexW-1:0] CfgSpareHigh = 2'd3;

    localparam int IdlePercent  = 15;
    localparam int PhaseItems   = 200;
    localparam int SettleCycles = 4;
    localparam int DrainCycles  = 8;
    localparam int CycleLimit   = 400000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_ready;
    logic [InDataW-1:0]   req_data;
    logic                 req_user;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    logic [OutDataW-1:0]  res_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CfgDataW-1:0]  cfg_data;

    int outstanding;
    int errors;
    int cycle_count = 0;
    bit steady_run = 1'b0;   // set to turn off idling on both sides

    // thresholds as last written, used to shape well-formed press sequences
    logic [PressW-1:0]   press_cfg;
    logic [ReleaseW-1:0] release_cfg;

    keypad_press_qualifier_unit uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .i_s_axis_tuser  (req_user),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    kpq_press_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_req_data    (req_data),
        .i_req_user    (req_user),
        .i_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .i_res_data    (res_data),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_outstanding (outstanding),
        .o_errors      (errors)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Stall the result stream at random, except during the steady stretch.
    always @(posedge clk) begin
        if (steady_run)
            res_ready <= 1'b1;
        else
            res_ready <= ($urandom_range(0, 99) >= IdlePercent);
    end

    // Bound the run; a hang or a lost result ends here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("tb_keypad_press_qualifier_unit: done, errors");
            $finish;
        end
    end

    // Offer one request and hold it until accepted. Valid stays high on return so
    // that a back-to-back request does not drop and raise it in the same step.
    task automatic send_request(input logic kind, input logic ok, input logic pressed,
                                input logic [KeyW-1:0] key);
        if (!steady_run) begin
            while ($urandom_range(0, 99) < IdlePercent) begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_valid <= 1'b1;
        req_user  <= kind;
        req_data  <= InDataW'({key, pressed, ok});
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic scan(input logic pressed, input logic [KeyW-1:0] key);
        send_request(KindScan, 1'b1, pressed, key);
    endtask

    task automatic consume();
        // the scan fields are junk on a consume and must be ignored
        send_request(KindConsume, 1'($urandom), 1'($urandom), 8'($urandom));
    endtask

    // Drop valid and wait until every expected result has come back and the
    // pipeline has emptied.
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_register(input logic [CfgIndexW-1:0] index,
                                  input logic [CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (index == CfgPressScans)
            press_cfg = data[PressW-1:0];
        else if (index == CfgReleaseScans)
            release_cfg = data;
    endtask

    task automatic set_thresholds(input logic [CfgDataW-1:0] press_data,
                                  input logic [CfgDataW-1:0] release_data);
        settle();
        write_register(CfgPressScans, press_data);
        write_register(CfgReleaseScans, release_data);
    endtask

    // One random request of any shape: failed scans, unresolved keys, stray consumes.
    task automatic noise_request(inout int count);
        logic [KeyW-1:0] key;
        key = ($urandom_range(0, 5) == 0) ? '0 : 8'($urandom);
        if ($urandom_range(0, 4) == 0)
            consume();
        else
            send_request(KindScan, ($urandom_range(0, 99) >= 15), 1'($urandom), key);
        count++;
    endtask

    // A well-formed press: hold one key long enough, take the event, then let go
    // long enough to release. Some runs are cut short or get a bad scan mixed in.
    task automatic press_sequence(inout int count);
        logic [KeyW-1:0] key;
        int              hold;
        int              idle;
        key  = 8'($urandom_range(1, 255));
        hold = press_cfg + $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0)
            hold = $urandom_range(0, hold);
        for (int n = 0; n < hold; n++) begin
            if ($urandom_range(0, 11) == 0)
                send_request(KindScan, 1'b0, 1'($urandom), 8'($urandom));
            else
                scan(1'b1, key);
            count++;
        end
        if ($urandom_range(0, 4) != 0) begin
            consume();
            count++;
        end
        idle = release_cfg + 1 + $urandom_range(0, 2);
        if ($urandom_range(0, 7) == 0)
            idle = $urandom_range(0, idle);
        for (int n = 0; n < idle; n++) begin
            // key field is ignored on idle scans; vary it anyway
            scan(1'b0, 8'($urandom));
            count++;
        end
    endtask

    task automatic random_phase(input int budget);
        int count;
        count = 0;
        while (count < budget) begin
            if ($urandom_range(0, 3) == 0)
                noise_request(count);
            else
                press_sequence(count);
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        req_user  = KindScan;
        cfg_valid = 1'b0;
        cfg_index = CfgPressScans;
        cfg_data  = '0;
        press_cfg   = PressScansReset;
        release_cfg = ReleaseScansReset;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset thresholds (press 2, release 8).
        send_request(KindConsume, 1'b1, 1'b1, 8'hFF);  // empty slot, junk fields
        send_request(KindScan, 1'b0, 1'b1, 8'h41);     // failed scan changes nothing
        scan(1'b1, 8'h00);                             // pressed but key unresolved
        scan(1'b1, 8'hFF);
        scan(1'b1, 8'hFF);                             // accepted: pending and latched
        scan(1'b0, 8'h00);
        scan(1'b1, 8'h80);                             // pressed while pending
        consume();                                     // returns the max key
        scan(1'b1, 8'h01);                             // pressed while latched
        repeat (9) scan(1'b0, 8'hAA);                  // count up, then release
        scan(1'b1, 8'h01);
        scan(1'b1, 8'h02);                             // candidate changes
        scan(1'b1, 8'h02);
        consume();

        // Directed, both thresholds zero; spare indexes must not disturb them.
        set_thresholds(8'h00, 8'h00);
        write_register(CfgSpareLow, 8'hFF);
        write_register(CfgSpareHigh, 8'h5A);
        scan(1'b1, 8'h7F);                             // accepted on first scan
        consume();
        scan(1'b0, 8'h00);                             // released on first idle scan
        scan(1'b1, 8'h7F);
        consume();

        // Random phases across threshold settings, extremes included.
        set_thresholds(8'hF1, 8'd3);
        random_phase(PhaseItems);
        set_thresholds(8'hAF, 8'd255);
        random_phase(PhaseItems);
        set_thresholds(8'h00, 8'd0);
        random_phase(PhaseItems);
        set_thresholds(8'h03, 8'd1);
        random_phase(PhaseItems);
        set_thresholds(8'($urandom), 8'($urandom_range(0, 20)));
        write_register(CfgSpareHigh, 8'($urandom));
        random_phase(PhaseItems);

        // Run one stretch with no idling on either side.
        set_thresholds(8'h02, 8'd8);
        steady_run = 1'b1;
        random_phase(PhaseItems);
        steady_run = 1'b0;

        settle();
        repeat (DrainCycles) @(posedge clk);
        if (errors == 0)
            $display("tb_keypad_press_qualifier_unit: done, clean");
        else
            $display("tb_keypad_press_qualifier_unit: done, errors");
        $finish;
    end

endmodule
